>>> sv/assert_macros.svh
// Assertion helpers for the port checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AST_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/utf8d_pkg.sv
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;

    // Result descriptor for one accepted byte: a run of invalid results,
    // then an optional tail result.
    typedef struct packed {
        logic [1:0]      n_pre;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_inv;
    } desc_t;

endpackage

>>> sv/utf8_stream_decoder_core.sv
// Streaming UTF-8 decoder, one byte per request in, code points out.
// Input channel: in_valid / in_stall / in_byte. A request is taken on a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with code_point, invalid, last.
// A byte yields 0 to 4 results; last marks the final one for that byte.
// A lead byte that opens a sequence yields no result of its own. invalid results
// carry code_point 0.
// Results pass the pending register, then the output register. Throughput:
// 1 byte per cycle while out_stall is low and each byte yields at most one
// result. A byte with n > 1 results (interrupted sequence) holds in_stall
// until the pending stage, draining one result per cycle while out_stall is
// low, has one left. When out_stall is high the output register holds; the
// pending stage still takes requests until it holds one with results, then
// in_stall rises. Reset clears the open sequence and empties both result stages.
`timescale 1ns / 1ps

module utf8_stream_decoder_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 in_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [utf8d_pkg::CP_W-1:0] code_point,
    output logic                       invalid,
    output logic                       last
);

    utf8d_pkg::desc_t desc;
    logic             accept;

    assign accept = in_valid && !in_stall;

    utf8d_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .desc    (desc)
    );

    utf8d_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .desc       (desc),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .invalid    (invalid),
        .last       (last)
    );

endmodule

>>> sv/utf8d_decode.sv
`timescale 1ns / 1ps

module utf8d_decode
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    output utf8d_pkg::desc_t desc
);

    logic [utf8d_pkg::CP_W-1:0] pv_reg;
    logic [utf8d_pkg::CP_W-1:0] pv_next;
    logic [1:0]                 need_reg;
    logic [1:0]                 need_next;
    logic [1:0]                 taken_reg;
    logic [1:0]                 taken_next;

    logic                       cont;
    logic [utf8d_pkg::CP_W-1:0] pv_shift;
    logic [1:0]                 taken_inc;
    logic                       out_of_range;

    assign cont         = (in_byte[7:6] == 2'b10);
    assign pv_shift     = {pv_reg[utf8d_pkg::CP_W-7:0], in_byte[5:0]};
    assign taken_inc    = taken_reg + 2'd1;
    assign out_of_range = (pv_shift > utf8d_pkg::CP_MAX) ||
                          ((pv_shift >= utf8d_pkg::SURR_LO) &&
                           (pv_shift <= utf8d_pkg::SURR_HI));

    always_comb
    begin
        pv_next       = pv_reg;
        need_next     = need_reg;
        taken_next    = taken_reg;
        desc.n_pre    = 2'd0;
        desc.has_tail = 1'b0;
        desc.tail_cp  = '0;
        desc.tail_inv = 1'b0;

        if ((need_reg != 2'd0) && cont)
        begin
            if (taken_inc == need_reg)
            begin
                desc.has_tail = 1'b1;
                desc.tail_inv = out_of_range;
                desc.tail_cp  = out_of_range ? '0 : pv_shift;
                pv_next       = '0;
                need_next     = 2'd0;
                taken_next    = 2'd0;
            end
            else
            begin
                pv_next    = pv_shift;
                taken_next = taken_inc;
            end
        end
        else
        begin
            // interrupted sequence: lead plus each continuation taken
            if (need_reg != 2'd0)
            begin
                desc.n_pre = taken_inc;
            end
            pv_next    = '0;
            need_next  = 2'd0;
            taken_next = 2'd0;
            priority if (in_byte[7] == 1'b0)
            begin
                desc.has_tail = 1'b1;
                desc.tail_cp  = {{(utf8d_pkg::CP_W-8){1'b0}}, in_byte};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                pv_next   = {{(utf8d_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
                need_next = 2'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                pv_next   = {{(utf8d_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
                need_next = 2'd2;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                pv_next   = {{(utf8d_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
                need_next = 2'd3;
            end
            else
            begin
                desc.has_tail = 1'b1;
                desc.tail_inv = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= '0;
            need_reg  <= 2'd0;
            taken_reg <= 2'd0;
        end
        else if (accept)
        begin
            pv_reg    <= pv_next;
            need_reg  <= need_next;
            taken_reg <= taken_next;
        end
    end

endmodule

>>> sv/utf8d_emit.sv
`timescale 1ns / 1ps

module utf8d_emit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  utf8d_pkg::desc_t           desc,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [utf8d_pkg::CP_W-1:0] code_point,
    output logic                       invalid,
    output logic                       last
);

    logic                       p_valid_reg;
    logic                       p_valid_next;
    logic [1:0]                 p_pre_reg;
    logic [1:0]                 p_pre_next;
    logic                       p_tail_reg;
    logic                       p_tail_next;
    logic [utf8d_pkg::CP_W-1:0] p_cp_reg;
    logic [utf8d_pkg::CP_W-1:0] p_cp_next;
    logic                       p_inv_reg;
    logic                       p_inv_next;

    logic                       o_valid_reg;
    logic                       o_valid_next;
    logic [utf8d_pkg::CP_W-1:0] o_cp_reg;
    logic [utf8d_pkg::CP_W-1:0] o_cp_next;
    logic                       o_inv_reg;
    logic                       o_inv_next;
    logic                       o_last_reg;
    logic                       o_last_next;

    logic o_free;
    logic p_one;
    logic accept;
    logic has_result;

    assign o_free     = !o_valid_reg || !out_stall;
    assign p_one      = ((p_pre_reg == 2'd1) && !p_tail_reg) ||
                        ((p_pre_reg == 2'd0) && p_tail_reg);
    assign in_stall   = p_valid_reg && !(o_free && p_one);
    assign accept     = in_valid && !in_stall;
    assign has_result = (desc.n_pre != 2'd0) || desc.has_tail;

    always_comb
    begin
        p_valid_next = p_valid_reg;
        p_pre_next   = p_pre_reg;
        p_tail_next  = p_tail_reg;
        p_cp_next    = p_cp_reg;
        p_inv_next   = p_inv_reg;
        o_valid_next = o_valid_reg;
        o_cp_next    = o_cp_reg;
        o_inv_next   = o_inv_reg;
        o_last_next  = o_last_reg;

        if (o_free)
        begin
            o_valid_next = p_valid_reg;
            if (p_valid_reg)
            begin
                if (p_pre_reg != 2'd0)
                begin
                    o_cp_next   = '0;
                    o_inv_next  = 1'b1;
                    o_last_next = p_one;
                    p_pre_next  = p_pre_reg - 2'd1;
                end
                else
                begin
                    o_cp_next   = p_cp_reg;
                    o_inv_next  = p_inv_reg;
                    o_last_next = 1'b1;
                    p_tail_next = 1'b0;
                end
                p_valid_next = !p_one;
            end
        end

        if (accept && has_result)
        begin
            p_valid_next = 1'b1;
            p_pre_next   = desc.n_pre;
            p_tail_next  = desc.has_tail;
            p_cp_next    = desc.tail_cp;
            p_inv_next   = desc.tail_inv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_pre_reg  <= p_pre_next;
        p_tail_reg <= p_tail_next;
        p_cp_reg   <= p_cp_next;
        p_inv_reg  <= p_inv_next;
        o_cp_reg   <= o_cp_next;
        o_inv_reg  <= o_inv_next;
        o_last_reg <= o_last_next;
    end

    assign out_valid  = o_valid_reg;
    assign code_point = o_cp_reg;
    assign invalid    = o_inv_reg;
    assign last       = o_last_reg;

endmodule

>>> sv/utf8d_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8d_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [utf8d_pkg::CP_W-1:0] code_point,
    input logic                       invalid,
    input logic                       last
);

    `AST_IMP(a_inv_zero, out_valid && invalid, code_point == '0)
    `AST_IMP(a_valid_range, out_valid && !invalid,
             (code_point <= utf8d_pkg::CP_MAX) &&
             ((code_point < utf8d_pkg::SURR_LO) || (code_point > utf8d_pkg::SURR_HI)))
    `AST_NEXT(a_burst_cont, out_valid && !out_stall && !last, out_valid)
    `AST_NEXT(a_out_hold, out_valid && out_stall,
              out_valid && $stable(code_point) && $stable(invalid) && $stable(last))
    `AST_NEXT(a_stall_drain, in_valid && in_stall && !out_stall, out_valid)

endmodule

bind utf8_stream_decoder_core utf8d_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .invalid    (invalid),
    .last       (last)
);

>>> tb/utf8_stream_decoder_core_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_core_test;

    localparam int CP_W = utf8d_pkg::CP_W;

    typedef enum logic [1:0]
    {
        ROW_PREDICT,
        ROW_NONE,
        ROW_SINGLE
    } row_kind_t;

    typedef struct
    {
        logic [7:0]      data;
        row_kind_t       kind;
        logic [CP_W-1:0] cp;
        logic            inv;
    } text_row_t;

    typedef struct
    {
        logic [CP_W-1:0] cp;
        logic            inv;
        logic            tail;
    } cp_result_t;

    localparam int TEXT_ITEMS = 270;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    logic [7:0]      in_byte = 8'h00;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            invalid;
    logic            last;

    text_row_t  text_rows[$];
    cp_result_t cp_scratch[$];
    cp_result_t cp_expected[$];

    logic [CP_W-1:0] seq_value = '0;
    logic [1:0]      seq_need = '0;
    logic [1:0]      seq_taken = '0;

    int next_item = 0;
    int mismatches = 0;
    int cyc = 0;
    logic calm;

    utf8_stream_decoder_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .code_point (code_point),
        .invalid    (invalid),
        .last       (last)
    );

    always #2 clk = ~clk;

    assign calm = (cyc >= 120) && (cyc < 300);

    function automatic void add_row(logic [7:0] data, row_kind_t kind,
                                    logic [CP_W-1:0] cp, logic inv);
        text_row_t r;
        r.data = data;
        r.kind = kind;
        r.cp   = cp;
        r.inv  = inv;
        text_rows.push_back(r);
    endfunction

    function automatic void emit(logic [CP_W-1:0] cp, logic inv);
        cp_result_t r;
        r.cp   = inv ? '0 : cp;
        r.inv  = inv;
        r.tail = 1'b0;
        cp_scratch.push_back(r);
    endfunction

    function automatic void note_mismatch(string what);
        if (mismatches < 10)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        logic [CP_W-1:0] full;
        cp_scratch.delete();
        if (seq_need != 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                seq_value = {seq_value[CP_W-7:0], b[5:0]};
                seq_taken++;
                if (seq_taken >= seq_need)
                begin
                    full = seq_value;
                    emit(full, (full > utf8d_pkg::CP_MAX) ||
                               (full >= utf8d_pkg::SURR_LO && full <= utf8d_pkg::SURR_HI));
                    seq_value = '0;
                    seq_need  = '0;
                    seq_taken = '0;
                    cp_scratch[cp_scratch.size()-1].tail = 1'b1;
                end
                return;
            end
            emit('0, 1'b1);
            repeat (seq_taken)
                emit('0, 1'b1);
            seq_value = '0;
            seq_need  = '0;
            seq_taken = '0;
        end
        if (b[7] == 1'b0)
            emit(CP_W'(b), 1'b0);
        else if (b[7:5] == 3'b110)
        begin
            seq_value = CP_W'(b[4:0]);
            seq_need  = 2'd1;
            seq_taken = '0;
        end
        else if (b[7:4] == 4'b1110)
        begin
            seq_value = CP_W'(b[3:0]);
            seq_need  = 2'd2;
            seq_taken = '0;
        end
        else if (b[7:3] == 5'b11110)
        begin
            seq_value = CP_W'(b[2:0]);
            seq_need  = 2'd3;
            seq_taken = '0;
        end
        else
            emit('0, 1'b1);
        if (cp_scratch.size() > 0)
            cp_scratch[cp_scratch.size()-1].tail = 1'b1;
    endtask

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // request side
    always @(posedge clk)
    begin
        cp_result_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte);
                case (text_rows[next_item].kind)
                    ROW_PREDICT:
                        foreach (cp_scratch[i])
                            cp_expected.push_back(cp_scratch[i]);
                    ROW_SINGLE:
                    begin
                        r.cp   = text_rows[next_item].cp;
                        r.inv  = text_rows[next_item].inv;
                        r.tail = 1'b1;
                        cp_expected.push_back(r);
                    end
                    default: ;
                endcase
                next_item++;
            end
            if (!in_valid || !in_stall)
            begin
                if (next_item < text_rows.size() && (calm || $urandom_range(99) >= 30))
                begin
                    in_valid <= 1'b1;
                    in_byte  <= text_rows[next_item].data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        cp_result_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (cp_expected.size() == 0)
                    note_mismatch($sformatf("unexpected result cp=%h inv=%b last=%b",
                                            code_point, invalid, last));
                else
                begin
                    e = cp_expected.pop_front();
                    if (code_point !== e.cp || invalid !== e.inv || last !== e.tail)
                        note_mismatch($sformatf(
                            "expected cp=%h inv=%b last=%b, got cp=%h inv=%b last=%b",
                            e.cp, e.inv, e.tail, code_point, invalid, last));
                end
            end
            out_stall <= !calm && ($urandom_range(99) < 30);
        end
    end

    initial
    begin
        int pick;
        int len;
        int cut;
        logic [7:0] b;

        add_row(8'h00, ROW_SINGLE, 21'h000000, 1'b0);
        add_row(8'h7F, ROW_SINGLE, 21'h00007F, 1'b0);
        add_row(8'h80, ROW_SINGLE, 21'h000000, 1'b1);
        add_row(8'hBF, ROW_SINGLE, 21'h000000, 1'b1);
        add_row(8'hF8, ROW_SINGLE, 21'h000000, 1'b1);
        add_row(8'hFF, ROW_SINGLE, 21'h000000, 1'b1);
        add_row(8'hC2, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'hA9, ROW_SINGLE, 21'h0000A9, 1'b0);
        add_row(8'hE2, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'h82, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'hAC, ROW_SINGLE, 21'h0020AC, 1'b0);
        // largest value the encoding can carry, above the scalar range
        add_row(8'hF7, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'hBF, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'hBF, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'hBF, ROW_SINGLE, 21'h000000, 1'b1);
        // surrogate
        add_row(8'hED, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'hA0, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'h80, ROW_SINGLE, 21'h000000, 1'b1);
        // interrupted after two continuations
        add_row(8'hF0, ROW_PREDICT, '0, 1'b0);
        add_row(8'h90, ROW_PREDICT, '0, 1'b0);
        add_row(8'h80, ROW_PREDICT, '0, 1'b0);
        add_row(8'h41, ROW_PREDICT, '0, 1'b0);
        // overlong zero
        add_row(8'hC0, ROW_NONE,   21'h000000, 1'b0);
        add_row(8'h80, ROW_SINGLE, 21'h000000, 1'b0);
        add_row(8'hF4, ROW_PREDICT, '0, 1'b0);
        add_row(8'hC3, ROW_PREDICT, '0, 1'b0);

        while (text_rows.size() < TEXT_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                len = $urandom_range(1, 4);
                cut = (pick < 70 || len == 1) ? len : $urandom_range(1, len - 1);
                case (len)
                    1: b = 8'($urandom_range(0, 127));
                    2: b = 8'hC0 | 8'($urandom_range(0, 31));
                    3: b = 8'hE0 | 8'($urandom_range(0, 15));
                    default: b = 8'hF0 | 8'($urandom_range(0, 7));
                endcase
                add_row(b, ROW_PREDICT, '0, 1'b0);
                for (int i = 1; i < cut; i++)
                    add_row(8'h80 | 8'($urandom_range(0, 63)), ROW_PREDICT, '0, 1'b0);
                if (cut < len)
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b[7:6] == 2'b10);
                    add_row(b, ROW_PREDICT, '0, 1'b0);
                end
            end
            else
                add_row(8'($urandom_range(0, 255)), ROW_PREDICT, '0, 1'b0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (next_item < text_rows.size())
            @(posedge clk);
        for (int i = 0; i < 2000 && cp_expected.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (cp_expected.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", cp_expected.size()));

        if (mismatches == 0)
            $display("PASS utf8_stream_decoder_core");
        else
            $display("FAIL utf8_stream_decoder_core");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL utf8_stream_decoder_core");
        $finish;
    end

endmodule
